// ===== rtl/core/bsae_pkg.sv =====
// ----------------------------------------------------------------------------
// bsae_pkg: shared types and constants of the back-EMF speed/angle estimator
// Fixed-point formats, the micro-step table of the shared multiply unit, the
// CORDIC arctangent table and the register map of the configuration port.
// ----------------------------------------------------------------------------
package bsae_pkg;

  // Field formats: signed Q16.16 data, angle in Q3.29 internally.
  localparam int DATA_W          = 32;
  localparam int RS_W            = 31;
  localparam int ANG_OUT_W       = 19;
  localparam int DEG_OUT_W       = 25;
  localparam int ACC_FRAC        = 29;
  localparam int ANG_SHIFT       = ACC_FRAC - 16;

  // Configuration port.
  localparam int ADDR_W          = 5;
  localparam int PDATA_W         = 32;

  // Shared multiply unit: 34 bit signed operands, magnitudes multiplied.
  localparam int OPW             = 34;
  localparam int PRODW           = 2 * OPW;
  localparam int ACCW            = 64;

  // CORDIC formats and limits.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX      = 24;
  localparam int IDX_W           = 5;
  localparam int ZW              = 35;
  localparam int XW              = 34;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

  // Angle wrap: modulus 6.28 in Q3.29, reduced by shifted subtraction.
  localparam int WRAPW           = 48;
  localparam int WRAP_TOP        = 14;
  localparam logic [WRAPW-1:0] WRAP_Q29 = 48'd3371549327;
  localparam logic [OPW-1:0]   DEG_Q16  = 34'd3754939;

  // Sequencer steps of the multiply unit.
  localparam int STEP_W          = 4;
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ANGLE = 4'd10;
  localparam logic [STEP_W-1:0] STEP_DEG   = 4'd11;

  typedef enum logic [3:0] {
    S_IDLE, S_CRED, S_CPREP, S_CITER, S_CFIN,
    S_OPD, S_MUL, S_RND, S_ACC, S_WINIT, S_WITER, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_RS, REG_LR, REG_INVK, REG_TS, REG_RPM
  } reg_idx_t;

  typedef enum logic [3:0] {
    A_IA, A_IB, A_DA, A_DB, A_EA, A_EB, A_SPDIN, A_SPD, A_ANG
  } a_sel_t;

  typedef enum logic [2:0] {
    B_RS, B_LR, B_COS, B_SIN, B_INVK, B_RPM, B_TS, B_DEG
  } b_sel_t;

  typedef enum logic [1:0] {
    SH16, SH19, SH29, SH30
  } sh_sel_t;

  typedef enum logic [2:0] {
    BASE_ZERO, BASE_ACC, BASE_UA, BASE_UB, BASE_ANG
  } base_sel_t;

  typedef enum logic [2:0] {
    DEST_NONE, DEST_EA, DEST_EB, DEST_UD, DEST_UQ, DEST_SPD, DEST_RPM, DEST_DEG
  } dest_t;

  typedef struct packed {
    a_sel_t    a;
    b_sel_t    b;
    sh_sel_t   sh;
    base_sel_t base;
    logic      sub;
    dest_t     dest;
  } step_ctl_t;

  // One product per step: result = base +/- round(a*b >> sh).
  function automatic step_ctl_t step_ctl(input logic [STEP_W-1:0] step);
    step_ctl_t c;
    unique case (step)
      4'd0:    c = '{A_IA,    B_RS,   SH16, BASE_UA,   1'b1, DEST_NONE};
      4'd1:    c = '{A_DA,    B_LR,   SH16, BASE_ACC,  1'b1, DEST_EA};
      4'd2:    c = '{A_IB,    B_RS,   SH16, BASE_UB,   1'b1, DEST_NONE};
      4'd3:    c = '{A_DB,    B_LR,   SH16, BASE_ACC,  1'b1, DEST_EB};
      4'd4:    c = '{A_EA,    B_COS,  SH30, BASE_ZERO, 1'b0, DEST_NONE};
      4'd5:    c = '{A_EB,    B_SIN,  SH30, BASE_ACC,  1'b0, DEST_UD};
      4'd6:    c = '{A_EB,    B_COS,  SH30, BASE_ZERO, 1'b0, DEST_NONE};
      4'd7:    c = '{A_EA,    B_SIN,  SH30, BASE_ACC,  1'b1, DEST_UQ};
      4'd8:    c = '{A_SPDIN, B_INVK, SH16, BASE_ZERO, 1'b0, DEST_SPD};
      4'd9:    c = '{A_SPD,   B_RPM,  SH16, BASE_ZERO, 1'b0, DEST_RPM};
      4'd10:   c = '{A_SPD,   B_TS,   SH19, BASE_ANG,  1'b0, DEST_NONE};
      4'd11:   c = '{A_ANG,   B_DEG,  SH29, BASE_ZERO, 1'b0, DEST_DEG};
      default: c = '{A_IA,    B_RS,   SH16, BASE_ZERO, 1'b0, DEST_NONE};
    endcase
    return c;
  endfunction

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 35'sd843314857;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043837;
      5'd3:    v = 35'sd133525159;
      5'd4:    v = 35'sd67021687;
      5'd5:    v = 35'sd33543516;
      5'd6:    v = 35'sd16775851;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194283;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048576;
      5'd11:   v = 35'sd524288;
      5'd12:   v = 35'sd262144;
      5'd13:   v = 35'sd131072;
      5'd14:   v = 35'sd65536;
      5'd15:   v = 35'sd32768;
      5'd16:   v = 35'sd16384;
      5'd17:   v = 35'sd8192;
      5'd18:   v = 35'sd4096;
      5'd19:   v = 35'sd2048;
      5'd20:   v = 35'sd1024;
      5'd21:   v = 35'sd512;
      5'd22:   v = 35'sd256;
      5'd23:   v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed sum to the data width.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] hi;
    logic signed [ACCW-1:0] lo;
    hi = ACCW'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bemf_speed_angle_estimator.sv =====
// ----------------------------------------------------------------------------
// bemf_speed_angle_estimator: voltage-model back-EMF speed and angle observer
// Forms the back-EMF from currents and voltages, rotates it into d/q with a
// CORDIC, derives speed and rpm, and integrates speed into a wrapped angle.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     in_valid / in_stall        in_current_*, in_voltage_*
//  result    out_valid / out_stall      out_emf_*, out_speed_*, out_angle_*
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// An item runs through the CORDIC states S_CRED, S_CPREP, S_CITER and
// S_CFIN, then 12 products on the one shared multiplier, each through
// S_OPD, S_MUL, S_RND and S_ACC, with the angle wrap in S_WINIT and
// S_WITER between the angle product and the degree product, and last
// the hand-off in S_DONE.
// A new item is taken only in idle, not before the last one is handed off.
// Reset is synchronous and active low; it restores the register defaults
// and clears the stored currents and angle.
// A stalled result holds in the output register; the sequencer waits for it.
// ----------------------------------------------------------------------------
module bemf_speed_angle_estimator
  import bsae_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_current_alpha,
  input  logic signed [DATA_W-1:0] in_current_beta,
  input  logic signed [DATA_W-1:0] in_voltage_alpha,
  input  logic signed [DATA_W-1:0] in_voltage_beta,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_emf_alpha,
  output logic signed [DATA_W-1:0] out_emf_beta,
  output logic signed [DATA_W-1:0] out_emf_direct,
  output logic signed [DATA_W-1:0] out_emf_quadrature,
  output logic signed [DATA_W-1:0] out_speed_rad,
  output logic signed [DATA_W-1:0] out_speed_rpm,
  output logic [ANG_OUT_W-1:0]     out_angle_rad,
  output logic [DEG_OUT_W-1:0]     out_angle_deg,
  // Configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam logic [IDX_W-1:0] CORDIC_LAST = IDX_W'(CORDIC_STEPS - 1);

  // Configuration registers
  logic [RS_W-1:0]   rs_r, lr_r, invk_r, rpm_scale_r;
  logic [DATA_W-1:0] ts_r;

  // Item and state registers
  state_t state_r, state_nxt;
  logic signed [DATA_W-1:0] ia_r, ib_r, ua_r, ub_r, last_a_r, last_b_r;
  logic [DATA_W-1:0] angle_r;
  logic signed [DATA_W-1:0] ea_r, eb_r, ud_r, uq_r, spd_r, rpm_r;
  logic [DEG_OUT_W-1:0] deg_r;
  logic [STEP_W-1:0] step_r;
  logic [IDX_W-1:0]  cnt_r;

  // CORDIC registers
  logic signed [ZW-1:0] z_r;
  logic signed [XW-1:0] x_r, y_r, cos_r, sin_r;
  logic                 flip_r;

  // Multiply unit registers
  logic [OPW-1:0]          mag_a_r, mag_b_r;
  logic                    neg_r;
  logic [PRODW-1:0]        prod_r;
  logic [ACCW-1:0]         rnd_r;
  logic signed [ACCW-1:0]  acc_r;
  logic [WRAPW-1:0]        wrap_r;

  // Output registers
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] o_ea_r, o_eb_r, o_ud_r, o_uq_r, o_spd_r, o_rpm_r;
  logic [ANG_OUT_W-1:0]     o_ang_r;
  logic [DEG_OUT_W-1:0]     o_deg_r;

  step_ctl_t ctl;
  logic signed [OPW-1:0]  op_a, op_b;
  logic signed [OPW-1:0]  uq_w, ud_w;
  logic [PRODW-1:0]       half, rsum;
  logic signed [ACCW-1:0] base, term, acc_nxt;
  logic                   flip_sum;
  logic signed [ZW-1:0]   theta;
  logic                   z_pos;
  logic signed [XW-1:0]   x_sh, y_sh;
  logic [WRAPW-1:0]       wrap_sub;
  logic                   cfg_wr, accept, out_free;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration write and reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r        <= '0;
      lr_r        <= '0;
      invk_r      <= RS_W'(65536);
      ts_r        <= DATA_W'(858993);
      rpm_scale_r <= RS_W'(625822);
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_RS:   rs_r        <= pwdata[RS_W-1:0];
        REG_LR:   lr_r        <= pwdata[RS_W-1:0];
        REG_INVK: invk_r      <= pwdata[RS_W-1:0];
        REG_TS:   ts_r        <= pwdata;
        REG_RPM:  rpm_scale_r <= pwdata[RS_W-1:0];
        default:  ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_RS:   prdata = {1'b0, rs_r};
      REG_LR:   prdata = {1'b0, lr_r};
      REG_INVK: prdata = {1'b0, invk_r};
      REG_TS:   prdata = ts_r;
      REG_RPM:  prdata = {1'b0, rpm_scale_r};
      default:  prdata = '0;
    endcase
  end

  // Operand selection for the shared multiplier.
  assign ctl  = step_ctl(step_r);
  assign uq_w = OPW'(uq_r);
  assign ud_w = OPW'(ud_r);

  always_comb begin
    case (ctl.a)
      A_IA:    op_a = OPW'(ia_r);
      A_IB:    op_a = OPW'(ib_r);
      A_DA:    op_a = OPW'(ia_r) - OPW'(last_a_r);
      A_DB:    op_a = OPW'(ib_r) - OPW'(last_b_r);
      A_EA:    op_a = OPW'(ea_r);
      A_EB:    op_a = OPW'(eb_r);
      A_SPDIN: op_a = (uq_r >= 0) ? (uq_w + ud_w) : (uq_w - ud_w);
      A_SPD:   op_a = OPW'(spd_r);
      A_ANG:   op_a = $signed({2'b00, angle_r});
      default: op_a = '0;
    endcase
    case (ctl.b)
      B_RS:    op_b = $signed({3'b000, rs_r});
      B_LR:    op_b = $signed({3'b000, lr_r});
      B_COS:   op_b = cos_r;
      B_SIN:   op_b = sin_r;
      B_INVK:  op_b = $signed({3'b000, invk_r});
      B_RPM:   op_b = $signed({3'b000, rpm_scale_r});
      B_TS:    op_b = $signed({2'b00, ts_r});
      B_DEG:   op_b = $signed(DEG_Q16);
      default: op_b = '0;
    endcase
  end

  // Rounding of the magnitude product, half away from zero.
  always_comb begin
    case (ctl.sh)
      SH16:    half = PRODW'(1) << 15;
      SH19:    half = PRODW'(1) << 18;
      SH29:    half = PRODW'(1) << 28;
      SH30:    half = PRODW'(1) << 29;
      default: half = '0;
    endcase
    rsum = prod_r + half;
  end

  // Accumulate: base plus or minus the rounded product.
  always_comb begin
    case (ctl.base)
      BASE_ZERO: base = '0;
      BASE_ACC:  base = acc_r;
      BASE_UA:   base = ACCW'(ua_r);
      BASE_UB:   base = ACCW'(ub_r);
      BASE_ANG:  base = $signed({32'd0, angle_r});
      default:   base = '0;
    endcase
    flip_sum = ctl.sub ^ neg_r;
    term     = flip_sum ? -$signed(rnd_r) : $signed(rnd_r);
    acc_nxt  = base + term;
  end

  // CORDIC step and angle-wrap compare.
  assign theta    = $signed({2'b00, angle_r, 1'b0});
  assign z_pos    = (z_r >= 0);
  assign x_sh     = x_r >>> cnt_r;
  assign y_sh     = y_r >>> cnt_r;
  assign wrap_sub = WRAP_Q29 << cnt_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CRED;
      S_CRED:  state_nxt = S_CPREP;
      S_CPREP: state_nxt = S_CITER;
      S_CITER: if (cnt_r == CORDIC_LAST) state_nxt = S_CFIN;
      S_CFIN:  state_nxt = S_OPD;
      S_OPD:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_RND;
      S_RND:   state_nxt = S_ACC;
      S_ACC: begin
        if (step_r == STEP_ANGLE) begin
          state_nxt = S_WINIT;
        end else if (step_r == STEP_DEG) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_OPD;
        end
      end
      S_WINIT: state_nxt = S_WITER;
      S_WITER: if (cnt_r == '0) state_nxt = S_OPD;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state: sequencer, stored currents, angle and result flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_a_r    <= '0;
      last_b_r    <= '0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WITER && cnt_r == '0) begin
        angle_r <= (wrap_r >= wrap_sub) ? DATA_W'(wrap_r - wrap_sub)
                                        : wrap_r[DATA_W-1:0];
      end
      if (state_r == S_DONE && out_free) begin
        last_a_r    <= ia_r;
        last_b_r    <= ib_r;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: capture, CORDIC, multiply unit, wrap and hand-off.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ia_r <= in_current_alpha;
          ib_r <= in_current_beta;
          ua_r <= in_voltage_alpha;
          ub_r <= in_voltage_beta;
        end
      end
      S_CRED: begin
        z_r <= (theta > PI_Q30) ? (theta - TWO_PI_Q30) : theta;
      end
      S_CPREP: begin
        if (z_r > HALF_PI_Q30) begin
          z_r    <= z_r - PI_Q30;
          flip_r <= 1'b1;
        end else if (z_r < -HALF_PI_Q30) begin
          z_r    <= z_r + PI_Q30;
          flip_r <= 1'b1;
        end else begin
          flip_r <= 1'b0;
        end
        x_r   <= GAIN_Q30;
        y_r   <= '0;
        cnt_r <= '0;
      end
      S_CITER: begin
        if (z_pos) begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_q30(cnt_r);
        end else begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_q30(cnt_r);
        end
        cnt_r <= cnt_r + IDX_W'(1);
      end
      S_CFIN: begin
        cos_r  <= flip_r ? -x_r : x_r;
        sin_r  <= flip_r ? -y_r : y_r;
        step_r <= STEP_FIRST;
      end
      S_OPD: begin
        mag_a_r <= op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
        mag_b_r <= op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
        neg_r   <= op_a[OPW-1] ^ op_b[OPW-1];
      end
      S_MUL: begin
        prod_r <= PRODW'(mag_a_r) * PRODW'(mag_b_r);
      end
      S_RND: begin
        case (ctl.sh)
          SH16:    rnd_r <= ACCW'(rsum >> 16);
          SH19:    rnd_r <= ACCW'(rsum >> 19);
          SH29:    rnd_r <= ACCW'(rsum >> 29);
          SH30:    rnd_r <= ACCW'(rsum >> 30);
          default: rnd_r <= '0;
        endcase
      end
      S_ACC: begin
        acc_r <= acc_nxt;
        case (ctl.dest)
          DEST_EA:  ea_r  <= sat_data(acc_nxt);
          DEST_EB:  eb_r  <= sat_data(acc_nxt);
          DEST_UD:  ud_r  <= sat_data(acc_nxt);
          DEST_UQ:  uq_r  <= sat_data(acc_nxt);
          DEST_SPD: spd_r <= sat_data(acc_nxt);
          DEST_RPM: rpm_r <= sat_data(acc_nxt);
          DEST_DEG: deg_r <= acc_nxt[DEG_OUT_W-1:0];
          default:  ;
        endcase
        if (step_r != STEP_ANGLE && step_r != STEP_DEG) begin
          step_r <= step_r + STEP_W'(1);
        end
      end
      S_WINIT: begin
        // A negative sum is lifted by a multiple of the modulus first.
        wrap_r <= acc_r[ACCW-1] ? WRAPW'(acc_r + ACCW'(WRAP_Q29 << WRAP_TOP))
                                : acc_r[WRAPW-1:0];
        cnt_r  <= IDX_W'(WRAP_TOP);
      end
      S_WITER: begin
        if (wrap_r >= wrap_sub) begin
          wrap_r <= wrap_r - wrap_sub;
        end
        cnt_r <= cnt_r - IDX_W'(1);
        if (cnt_r == '0) begin
          step_r <= STEP_DEG;
        end
      end
      S_DONE: begin
        if (out_free) begin
          o_ea_r  <= ea_r;
          o_eb_r  <= eb_r;
          o_ud_r  <= ud_r;
          o_uq_r  <= uq_r;
          o_spd_r <= spd_r;
          o_rpm_r <= rpm_r;
          o_ang_r <= ANG_OUT_W'(angle_r >> ANG_SHIFT);
          o_deg_r <= deg_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_emf_alpha      = o_ea_r;
  assign out_emf_beta       = o_eb_r;
  assign out_emf_direct     = o_ud_r;
  assign out_emf_quadrature = o_uq_r;
  assign out_speed_rad      = o_spd_r;
  assign out_speed_rpm      = o_rpm_r;
  assign out_angle_rad      = o_ang_r;
  assign out_angle_deg      = o_deg_r;

endmodule

// ===== rtl/core/bsae_checker.sv =====
// ----------------------------------------------------------------------------
// bsae_checker: port-level checks of the back-EMF estimator
// Watches the handshakes and the angle outputs over time.
// ----------------------------------------------------------------------------
module bsae_checker
  import bsae_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [ANG_OUT_W-1:0] out_angle_rad,
  input logic [DEG_OUT_W-1:0] out_angle_deg
);

  // A result waiting on a stall is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An accepted item keeps the input side busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  // The wrapped angle stays below 6.28 rad; the floor of the largest
  // Q3.29 angle below the modulus is 411566 in Q16.
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_rad <= ANG_OUT_W'(411566))
    else $error("angle out of range");

  // The degree angle stays at or below 360 degrees.
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= DEG_OUT_W'(23592960))
    else $error("degree angle out of range");

endmodule

bind bemf_speed_angle_estimator bsae_checker u_bsae_checker (.*);
